// ===== sv/resbn_pkg.sv =====
// Shared types, widths and helpers for the record sorter.
package resbn_pkg;

  localparam int unsigned HEAD_W      = 64;
  localparam int unsigned MID_W       = 64;
  localparam int unsigned TAIL_W      = 32;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned KEY_W       = HEAD_W + MID_W + TAIL_W;
  localparam int unsigned REC_W       = KEY_W + POS_W;
  localparam int unsigned IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((REC_W + 7) / 8) * 8;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [KEY_W-1:0] key_t;

  // head sits in the low bits, position in the top bits
  typedef struct packed {
    pos_t              pos;
    logic [TAIL_W-1:0] tail;
    logic [MID_W-1:0]  middle;
    logic [HEAD_W-1:0] head;
  } rec_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WR_I,
    ST_E_RD,
    ST_E_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic last;
    logic dropped;
  } emit_t;

  // head field most significant, then middle, then tail; compared unsigned
  function automatic logic key_gt(rec_t a, rec_t b);
    key_t ka;
    key_t kb;
    ka = {a.head, a.middle, a.tail};
    kb = {b.head, b.middle, b.tail};
    return ka > kb;
  endfunction

endpackage

// ===== sv/record_exchange_sort_by_name.sv =====
// Top level of the record sorter: stream ports, record RAM, core and output register.
//
//  channel  | dir | tdata (low bit up)                   | tlast       | tuser
//  s_axis   | in  | name_head, name_middle, name_tail    | last_record | -
//  m_axis   | out | sorted_head, sorted_middle,          | final_out   | dropped_any
//           |     | sorted_tail, load_position, 4b zero  |             |
//
// Loading takes one beat per cycle. After the last record the sort runs on the
// single-port-read record RAM, one compare per cycle within a pass. Emission
// reads each record from the RAM, then loads it into the output register.
// Reset empties the set; RAM contents are left as they are. m_axis stalls hold
// the output register and pause emission; s_axis is taken only while loading.
module record_exchange_sort_by_name #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [resbn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // head, middle, tail
  input  logic                                 s_axis_tlast,  // last_record
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [resbn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // head, middle, tail, pos, pad
  output logic                                 m_axis_tlast,  // final_out
  output logic [0:0]                           m_axis_tuser   // dropped_any
);

  localparam int unsigned IDX_W = $clog2(MAX_RECORDS);

  resbn_pkg::rec_t  s_rec;
  resbn_pkg::rec_t  ram_wdata;
  resbn_pkg::rec_t  ram_rdata;
  resbn_pkg::emit_t emit;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic             out_free;

  resbn_pkg::rec_t  out_rec_q;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q;
  logic             out_drop_q;

  assign s_rec.head   = s_axis_tdata[resbn_pkg::HEAD_W-1:0];
  assign s_rec.middle = s_axis_tdata[resbn_pkg::HEAD_W +: resbn_pkg::MID_W];
  assign s_rec.tail   = s_axis_tdata[resbn_pkg::HEAD_W + resbn_pkg::MID_W +: resbn_pkg::TAIL_W];
  assign s_rec.pos    = '0;

  resbn_ram #(
    .WIDTH (resbn_pkg::REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  resbn_core #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_last_i    (s_axis_tlast),
    .s_rec_i     (s_rec),
    .s_ready_o   (s_axis_tready),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (emit.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_rec_q  <= ram_rdata;
      out_last_q <= emit.last;
      out_drop_q <= emit.dropped;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = resbn_pkg::OUT_TDATA_W'(out_rec_q);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_drop_q;

endmodule

// ===== sv/resbn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module resbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/resbn_core.sv =====
// Load sequencer, exchange-sort engine and emit sequencer around the record RAM.
module resbn_core #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  input  logic                             s_last_i,
  input  resbn_pkg::rec_t                  s_rec_i,
  output logic                             s_ready_o,
  input  logic                             out_free_i,
  output resbn_pkg::emit_t                 emit_o,
  output logic                             ram_we_o,
  output logic [$clog2(MAX_RECORDS)-1:0]   ram_waddr_o,
  output resbn_pkg::rec_t                  ram_wdata_o,
  output logic                             ram_re_o,
  output logic [$clog2(MAX_RECORDS)-1:0]   ram_raddr_o,
  input  resbn_pkg::rec_t                  ram_rdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

  resbn_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [IDX_W-1:0]  i_q, i_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic [IDX_W-1:0]  k_q, k_d;
  resbn_pkg::rec_t   cur_q, cur_d;
  logic [CNT_W-1:0]  top_idx;
  logic              room;

  assign top_idx = count_q - CNT_W'(1);
  assign room    = count_q < CNT_MAX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= resbn_pkg::ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    cur_d       = cur_q;
    s_ready_o   = 1'b0;
    emit_o      = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = count_q[IDX_W-1:0];
    ram_wdata_o = s_rec_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = i_q;
    unique case (state_q)
      resbn_pkg::ST_LOAD: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (room) begin
            ram_we_o        = 1'b1;
            ram_wdata_o.pos = resbn_pkg::pos_t'(count_q);
            count_d         = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_last_i) begin
            i_d = '0;
            k_d = '0;
            if (count_d >= CNT_W'(2)) begin
              state_d = resbn_pkg::ST_RD_I;
            end else begin
              state_d = resbn_pkg::ST_E_RD;
            end
          end
        end
      end
      resbn_pkg::ST_RD_I: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = i_q;
        state_d     = resbn_pkg::ST_LD_I;
      end
      resbn_pkg::ST_LD_I: begin
        cur_d       = ram_rdata_i;
        ram_re_o    = 1'b1;
        ram_raddr_o = i_q + IDX_W'(1);
        j_d         = i_q + IDX_W'(1);
        state_d     = resbn_pkg::ST_CMP;
      end
      resbn_pkg::ST_CMP: begin
        if (resbn_pkg::key_gt(cur_q, ram_rdata_i)) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = j_q;
          ram_wdata_o = cur_q;
          cur_d       = ram_rdata_i;
        end
        if (CNT_W'(j_q) == top_idx) begin
          state_d = resbn_pkg::ST_WR_I;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = j_q + IDX_W'(1);
          j_d         = j_q + IDX_W'(1);
        end
      end
      resbn_pkg::ST_WR_I: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = i_q;
        ram_wdata_o = cur_q;
        if (CNT_W'(i_q) + CNT_W'(1) == top_idx) begin
          k_d     = '0;
          state_d = resbn_pkg::ST_E_RD;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = i_q + IDX_W'(1);
          i_d         = i_q + IDX_W'(1);
          state_d     = resbn_pkg::ST_LD_I;
        end
      end
      resbn_pkg::ST_E_RD: begin
        if (out_free_i) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = k_q;
          state_d     = resbn_pkg::ST_E_OUT;
        end
      end
      resbn_pkg::ST_E_OUT: begin
        emit_o.load    = 1'b1;
        emit_o.last    = CNT_W'(k_q) == top_idx;
        emit_o.dropped = ovf_q;
        if (emit_o.last) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = resbn_pkg::ST_LOAD;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = resbn_pkg::ST_E_RD;
        end
      end
      default: begin
        state_d = resbn_pkg::ST_LOAD;
      end
    endcase
  end

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o && ram_re_o |-> ram_waddr_o != ram_raddr_o)
    else $error("read and write hit the same entry");

  a_out_free_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.load |-> out_free_i)
    else $error("output register overwritten before taken");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("record count beyond capacity");

  a_sort_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == resbn_pkg::ST_CMP |-> count_q >= CNT_W'(2) && CNT_W'(j_q) <= top_idx)
    else $error("compare outside stored records");

endmodule
